@@ hdl/hc26_pkg.sv @@
// Shared types, constants and modular helpers for the 2x2 mod-26 Hill cipher.
`timescale 1ns / 1ps
`default_nettype none

package hc26_pkg;

   localparam int LETTERS    = 26;
   localparam int LETTER_W   = 5;
   localparam int WIDE_W     = 11;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [WIDE_W-1:0]   wide_type;

   // Matrix entries are indexed [row][column].
   typedef letter_type [1:0][1:0] matrix_type;
   typedef letter_type [1:0]      pair_type;

   typedef enum logic {
      CMD_ENCRYPT = 1'b0,
      CMD_DECRYPT = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      REG_KEY_A = 2'd0,
      REG_KEY_B = 2'd1,
      REG_KEY_C = 2'd2,
      REG_KEY_D = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } stage_en_type;

   // Restoring reduction; valid for any value below 26 * 64.
   function automatic letter_type mod26(input wide_type x);
      wide_type r;
      wide_type step;
      r = x;
      for (int k = 5; k >= 0; k--) begin
         step = WIDE_W'(LETTERS) << k;
         if (r >= step) begin
            r = r - step;
         end
      end
      return r[LETTER_W-1:0];
   endfunction

   // Reduces a 5-bit value that may exceed 25.
   function automatic letter_type reduce(input letter_type v);
      return (v >= LETTER_W'(LETTERS)) ? letter_type'(v - LETTER_W'(LETTERS)) : v;
   endfunction

   // Additive inverse of a value already in 0..25.
   function automatic letter_type negate(input letter_type v);
      return (v == '0) ? '0 : letter_type'(LETTER_W'(LETTERS) - v);
   endfunction

   // Multiplicative inverse mod 26; zero means there is none.
   function automatic letter_type inverse(input letter_type v);
      letter_type r;
      unique case (v)
         5'd1:    r = 5'd1;
         5'd3:    r = 5'd9;
         5'd5:    r = 5'd21;
         5'd7:    r = 5'd15;
         5'd9:    r = 5'd3;
         5'd11:   r = 5'd19;
         5'd15:   r = 5'd7;
         5'd17:   r = 5'd23;
         5'd19:   r = 5'd11;
         5'd21:   r = 5'd5;
         5'd23:   r = 5'd17;
         5'd25:   r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/hc26_if.sv @@
// Valid/ready channel interfaces for the request and response items.
`timescale 1ns / 1ps
`default_nettype none

interface hc26_req_if;
   logic                 valid;
   logic                 ready;
   logic                 command;
   hc26_pkg::letter_type letter_first;
   hc26_pkg::letter_type letter_second;

   modport source (output valid, command, letter_first, letter_second, input ready);
   modport sink   (input valid, command, letter_first, letter_second, output ready);
endinterface

interface hc26_rsp_if;
   logic                 valid;
   logic                 ready;
   hc26_pkg::letter_type out_first;
   hc26_pkg::letter_type out_second;
   logic                 key_not_invertible;

   modport source (output valid, out_first, out_second, key_not_invertible, input ready);
   modport sink   (input valid, out_first, out_second, key_not_invertible, output ready);
endinterface

`default_nettype wire

@@ hdl/hc26_matrix.sv @@
// Three-stage pipeline that picks the key or its inverse mod 26 for each item.
`timescale 1ns / 1ps
`default_nettype none

module hc26_matrix (
   input  wire logic                   clock,
   input  wire hc26_pkg::stage_en_type ctl,
   input  wire logic                   command,
   input  wire hc26_pkg::letter_type   letter_first,
   input  wire hc26_pkg::letter_type   letter_second,
   input  wire hc26_pkg::matrix_type   key,
   output hc26_pkg::matrix_type        matrix,
   output hc26_pkg::pair_type          letters,
   output logic                        not_invertible
);

   // Stage 1: reduced operands and the two determinant products.
   logic                 cmd1_ff;
   hc26_pkg::pair_type   let1_ff;
   hc26_pkg::matrix_type key1_ff;
   logic [9:0]           ad1_ff;
   logic [9:0]           bc1_ff;
   hc26_pkg::matrix_type key1_in;

   // Stage 2: determinant inverse.
   logic                 cmd2_ff;
   hc26_pkg::pair_type   let2_ff;
   hc26_pkg::matrix_type key2_ff;
   hc26_pkg::letter_type dinv2_ff;
   hc26_pkg::letter_type adm;
   hc26_pkg::letter_type bcm;
   hc26_pkg::letter_type det;

   // Stage 3: the matrix applied by the lanes.
   hc26_pkg::pair_type   let3_ff;
   hc26_pkg::matrix_type mat3_ff;
   logic                 flag3_ff;
   hc26_pkg::matrix_type mat3_in;
   logic                 flag3_in;

   always_comb begin
      for (int r = 0; r < 2; r++) begin
         for (int c = 0; c < 2; c++) begin
            key1_in[r][c] = hc26_pkg::reduce(key[r][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         cmd1_ff    <= command;
         let1_ff[0] <= hc26_pkg::reduce(letter_first);
         let1_ff[1] <= hc26_pkg::reduce(letter_second);
         key1_ff    <= key1_in;
         ad1_ff     <= 10'(key1_in[0][0]) * 10'(key1_in[1][1]);
         bc1_ff     <= 10'(key1_in[0][1]) * 10'(key1_in[1][0]);
      end
   end

   always_comb begin
      adm = hc26_pkg::mod26(hc26_pkg::wide_type'(ad1_ff));
      bcm = hc26_pkg::mod26(hc26_pkg::wide_type'(bc1_ff));
      if (adm >= bcm) begin
         det = hc26_pkg::letter_type'(adm - bcm);
      end else begin
         det = hc26_pkg::letter_type'(6'(adm) + 6'(hc26_pkg::LETTERS) - 6'(bcm));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en2) begin
         cmd2_ff  <= cmd1_ff;
         let2_ff  <= let1_ff;
         key2_ff  <= key1_ff;
         dinv2_ff <= hc26_pkg::inverse(det);
      end
   end

   // Inverse key is dinv times the adjugate; a zero dinv yields a zero matrix.
   always_comb begin
      if (cmd2_ff == hc26_pkg::CMD_ENCRYPT) begin
         mat3_in  = key2_ff;
         flag3_in = 1'b0;
      end else begin
         mat3_in[0][0] = hc26_pkg::mod26(hc26_pkg::wide_type'(
                            10'(key2_ff[1][1]) * 10'(dinv2_ff)));
         mat3_in[0][1] = hc26_pkg::mod26(hc26_pkg::wide_type'(
                            10'(hc26_pkg::negate(key2_ff[0][1])) * 10'(dinv2_ff)));
         mat3_in[1][0] = hc26_pkg::mod26(hc26_pkg::wide_type'(
                            10'(hc26_pkg::negate(key2_ff[1][0])) * 10'(dinv2_ff)));
         mat3_in[1][1] = hc26_pkg::mod26(hc26_pkg::wide_type'(
                            10'(key2_ff[0][0]) * 10'(dinv2_ff)));
         flag3_in      = (dinv2_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en3) begin
         let3_ff  <= let2_ff;
         mat3_ff  <= mat3_in;
         flag3_ff <= flag3_in;
      end
   end

   assign matrix         = mat3_ff;
   assign letters        = let3_ff;
   assign not_invertible = flag3_ff;

endmodule

`default_nettype wire

@@ hdl/hc26_lane.sv @@
// One output lane: a row of the matrix times the letter pair, mod 26, registered.
`timescale 1ns / 1ps
`default_nettype none

module hc26_lane (
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire hc26_pkg::letter_type coef_first,
   input  wire hc26_pkg::letter_type coef_second,
   input  wire hc26_pkg::pair_type   letters,
   output hc26_pkg::letter_type      result
);

   hc26_pkg::letter_type result_ff;
   hc26_pkg::wide_type   sum;

   // Both products stay below 626, so the sum is within the reducer's range.
   assign sum = hc26_pkg::wide_type'(10'(coef_first) * 10'(letters[0]))
              + hc26_pkg::wide_type'(10'(coef_second) * 10'(letters[1]));

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= hc26_pkg::mod26(sum);
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

@@ hdl/hill_cipher_2x2_mod26.sv @@
// Top level of the 2x2 mod-26 Hill cipher with its key registers and pipeline control.
`timescale 1ns / 1ps
`default_nettype none

// Each request item carries a command and a letter pair; encrypt multiplies the pair by the
// key matrix mod 26 and decrypt by the key's inverse mod 26, flagging a key whose determinant
// has no inverse (the letters then come back as zero). Letters and key entries of 26..31 act
// as their value mod 26. The block takes one item per cycle unless the response stalls. Three
// stages form the matrix (determinant products, determinant inverse, adjugate scaling) and two
// parallel lanes then compute the output letters into the response register. Stages with no
// item fill in while the response waits, so a stalled response stops input only once the
// pipeline is full. Key registers reset to zero and are written through the csr port; the user
// must write them only while no item is in flight, which the block itself does not enforce.
module hill_cipher_2x2_mod26 (
   input  wire logic                   clock,
   input  wire logic                   reset,
   hc26_req_if.sink                    req,
   hc26_rsp_if.source                  rsp,
   input  wire logic                   csr_write_enable,
   input  wire hc26_pkg::reg_index_type csr_index,
   input  wire hc26_pkg::letter_type   csr_write_data
);

   hc26_pkg::matrix_type   key_ff;
   logic                   v1_ff;
   logic                   v2_ff;
   logic                   v3_ff;
   logic                   out_valid_ff;
   logic                   flag_ff;
   logic                   en4;
   hc26_pkg::stage_en_type ctl;
   hc26_pkg::matrix_type   matrix;
   hc26_pkg::pair_type     letters;
   logic                   not_invertible;
   hc26_pkg::pair_type     lane_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            hc26_pkg::REG_KEY_A: key_ff[0][0] <= csr_write_data;
            hc26_pkg::REG_KEY_B: key_ff[0][1] <= csr_write_data;
            hc26_pkg::REG_KEY_C: key_ff[1][0] <= csr_write_data;
            hc26_pkg::REG_KEY_D: key_ff[1][1] <= csr_write_data;
         endcase
      end
   end

   // A stage may load when it is empty or when the stage after it moves.
   always_comb begin
      en4     = !out_valid_ff || rsp.ready;
      ctl.en3 = !v3_ff || en4;
      ctl.en2 = !v2_ff || ctl.en3;
      ctl.en1 = !v1_ff || ctl.en2;
   end

   assign req.ready = ctl.en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ctl.en1) begin
            v1_ff <= req.valid;
         end
         if (ctl.en2) begin
            v2_ff <= v1_ff;
         end
         if (ctl.en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            out_valid_ff <= v3_ff;
         end
      end
   end

   hc26_matrix u_matrix (
      .clock          (clock),
      .ctl            (ctl),
      .command        (req.command),
      .letter_first   (req.letter_first),
      .letter_second  (req.letter_second),
      .key            (key_ff),
      .matrix         (matrix),
      .letters        (letters),
      .not_invertible (not_invertible)
   );

   for (genvar g = 0; g < 2; g++) begin : g_lane
      hc26_lane u_lane (
         .clock       (clock),
         .enable      (en4),
         .coef_first  (matrix[g][0]),
         .coef_second (matrix[g][1]),
         .letters     (letters),
         .result      (lane_out[g])
      );
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         flag_ff <= not_invertible;
      end
   end

   assign rsp.valid              = out_valid_ff;
   assign rsp.out_first          = lane_out[0];
   assign rsp.out_second         = lane_out[1];
   assign rsp.key_not_invertible = flag_ff;

`ifndef NO_ASSERTIONS
   // A flagged key leaves the lanes with a zero matrix, so both letters are zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.key_not_invertible |-> rsp.out_first == '0 && rsp.out_second == '0)
      else $error("flagged response carries nonzero letters");

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.out_first < 5'd26 && rsp.out_second < 5'd26)
      else $error("response letter out of range");

   assert property (@(posedge clock) reset |=> !rsp.valid && !v1_ff && !v2_ff && !v3_ff)
      else $error("pipeline not empty after reset");

   // An accepted item always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> v1_ff)
      else $error("accepted item lost at pipeline entry");

   // A stalled response may only block input when every stage is occupied.
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> v1_ff && v2_ff && v3_ff && rsp.valid && !rsp.ready)
      else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire

@@ tb/tb_hill_cipher_2x2_mod26.sv @@
// Self-checking testbench for the 2x2 mod-26 Hill cipher: directed keys, random traffic, stalls.
`timescale 1ns / 1ps

module tb_hill_cipher_2x2_mod26;

   localparam int PIPE_LATENCY = 4;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      hc26_pkg::letter_type first;
      hc26_pkg::letter_type second;
      logic                 bad_key;
   } pair_result_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   hc26_pkg::reg_index_type csr_index;
   hc26_pkg::letter_type    csr_write_data;

   hc26_req_if req_ch ();
   hc26_rsp_if rsp_ch ();

   hill_cipher_2x2_mod26 dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   hc26_pkg::letter_type key_reg [4];
   pair_result_type      expected_pairs [$];
   int                   failures      = 0;
   int                   req_idle_pct  = 0;
   int                   rsp_stall_pct = 0;
   logic                 rsp_hold      = 1'b0;
   event                 hold_trigger;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int wrap26(input int v);
      int r;
      r = v % hc26_pkg::LETTERS;
      if (r < 0) begin
         r += hc26_pkg::LETTERS;
      end
      return r;
   endfunction

   // Expected output of one letter pair under the key currently loaded.
   function automatic pair_result_type hill_transform(input hc26_pkg::command_type cmd,
                                                      input hc26_pkg::letter_type f,
                                                      input hc26_pkg::letter_type s);
      int a, b, c, d, det, det_inv;
      int m00, m01, m10, m11;
      pair_result_type r;
      a = key_reg[hc26_pkg::REG_KEY_A];
      b = key_reg[hc26_pkg::REG_KEY_B];
      c = key_reg[hc26_pkg::REG_KEY_C];
      d = key_reg[hc26_pkg::REG_KEY_D];
      r.bad_key = 1'b0;
      if (cmd == hc26_pkg::CMD_ENCRYPT) begin
         m00 = a;
         m01 = b;
         m10 = c;
         m11 = d;
      end else begin
         det = wrap26(a * d - b * c);
         det_inv = 0;
         for (int x = hc26_pkg::LETTERS - 1; x >= 1; x--) begin
            if ((det * x) % hc26_pkg::LETTERS == 1) begin
               det_inv = x;
            end
         end
         r.bad_key = (det_inv == 0);
         m00 = wrap26(d * det_inv);
         m01 = wrap26(-b * det_inv);
         m10 = wrap26(-c * det_inv);
         m11 = wrap26(a * det_inv);
      end
      r.first  = hc26_pkg::letter_type'(wrap26(m00 * int'(f) + m01 * int'(s)));
      r.second = hc26_pkg::letter_type'(wrap26(m10 * int'(f) + m11 * int'(s)));
      return r;
   endfunction

   // Letters are mostly legal, with the odd out-of-range code 26..31.
   function automatic hc26_pkg::letter_type rand_letter();
      if ($urandom_range(0, 7) == 0) begin
         return hc26_pkg::letter_type'($urandom_range(26, 31));
      end
      return hc26_pkg::letter_type'($urandom_range(0, 25));
   endfunction

   function automatic hc26_pkg::command_type rand_command();
      return $urandom_range(0, 1) ? hc26_pkg::CMD_DECRYPT : hc26_pkg::CMD_ENCRYPT;
   endfunction

   task automatic send_pair(input hc26_pkg::command_type cmd, input hc26_pkg::letter_type f,
                            input hc26_pkg::letter_type s);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_ch.valid         <= 1'b1;
      req_ch.command       <= cmd;
      req_ch.letter_first  <= f;
      req_ch.letter_second <= s;
      do @(posedge clock); while (!req_ch.ready);
      expected_pairs.push_back(hill_transform(cmd, f, s));
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_pairs.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic load_key(input hc26_pkg::letter_type a, input hc26_pkg::letter_type b,
                           input hc26_pkg::letter_type c, input hc26_pkg::letter_type d);
      hc26_pkg::letter_type vals [4];
      vals = '{a, b, c, d};
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= hc26_pkg::reg_index_type'(i);
         csr_write_data   <= vals[i];
         @(posedge clock);
         key_reg[i] = vals[i];
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_key();
      send_pair(hc26_pkg::CMD_ENCRYPT, 5'd7, 5'd4);
      send_pair(hc26_pkg::CMD_DECRYPT, 5'd7, 5'd4);
   endtask

   task automatic test_directed_keys();
      // Identity key with the letter extremes and out-of-range codes.
      load_key(5'd1, 5'd0, 5'd0, 5'd1);
      send_pair(hc26_pkg::CMD_ENCRYPT, 5'd0, 5'd0);
      send_pair(hc26_pkg::CMD_ENCRYPT, 5'd25, 5'd25);
      send_pair(hc26_pkg::CMD_ENCRYPT, 5'd31, 5'd26);
      send_pair(hc26_pkg::CMD_DECRYPT, 5'd25, 5'd0);
      // Textbook invertible key.
      load_key(5'd3, 5'd3, 5'd2, 5'd5);
      send_pair(hc26_pkg::CMD_ENCRYPT, 5'd7, 5'd4);
      send_pair(hc26_pkg::CMD_DECRYPT, 5'd7, 5'd8);
      // Key entries above 25 with an even determinant: decrypt must flag it.
      load_key(5'd31, 5'd30, 5'd29, 5'd28);
      send_pair(hc26_pkg::CMD_DECRYPT, 5'd1, 5'd1);
      send_pair(hc26_pkg::CMD_ENCRYPT, 5'd31, 5'd31);
      // Negative raw determinant that is invertible once reduced.
      load_key(5'd1, 5'd3, 5'd2, 5'd1);
      send_pair(hc26_pkg::CMD_DECRYPT, 5'd10, 5'd20);
      send_pair(hc26_pkg::CMD_ENCRYPT, 5'd10, 5'd20);
      // Determinant thirteen shares a factor with 26.
      load_key(5'd13, 5'd0, 5'd0, 5'd1);
      send_pair(hc26_pkg::CMD_DECRYPT, 5'd5, 5'd5);
      load_key(5'd25, 5'd25, 5'd25, 5'd25);
      send_pair(hc26_pkg::CMD_DECRYPT, 5'd25, 5'd25);
      send_pair(hc26_pkg::CMD_ENCRYPT, 5'd25, 5'd25);
      load_key(5'd2, 5'd3, 5'd1, 5'd4);
      send_pair(hc26_pkg::CMD_ENCRYPT, 5'd31, 5'd0);
      send_pair(hc26_pkg::CMD_DECRYPT, 5'd31, 5'd0);
   endtask

   task automatic test_random_traffic();
      int                   idle_modes [4][2] = '{'{0, 0}, '{49, 0}, '{0, 49}, '{16, 16}};
      hc26_pkg::letter_type corner [3] = '{5'd0, 5'd25, 5'd31};
      hc26_pkg::letter_type k [4];
      int                   pick, det;
      hc26_pkg::letter_type f, s;
      pair_result_type      cipher;
      for (int phase = 0; phase < 4; phase++) begin
         for (int setting = 0; setting < 4; setting++) begin
            pick = $urandom_range(0, 7);
            // Half of the keys are forced invertible so round trips decode fully.
            do begin
               foreach (k[i]) begin
                  k[i] = (pick == 0) ? corner[$urandom_range(0, 2)] : rand_letter();
               end
               det = wrap26(int'(k[0]) * int'(k[3]) - int'(k[1]) * int'(k[2]));
            end while (pick >= 4 && (det % 2 == 0 || det % 13 == 0));
            load_key(k[0], k[1], k[2], k[3]);
            req_idle_pct  = idle_modes[phase][0];
            rsp_stall_pct = idle_modes[phase][1];
            for (int n = 0; n < 52; n++) begin
               f = rand_letter();
               s = rand_letter();
               if ($urandom_range(0, 2) == 0) begin
                  send_pair(rand_command(), f, s);
               end else begin
                  cipher = hill_transform(hc26_pkg::CMD_ENCRYPT, f, s);
                  send_pair(hc26_pkg::CMD_ENCRYPT, f, s);
                  send_pair(hc26_pkg::CMD_DECRYPT, cipher.first, cipher.second);
               end
            end
         end
      end
   endtask

   task automatic test_backpressure();
      wait_idle();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      -> hold_trigger;
      for (int n = 0; n < 40; n++) begin
         send_pair(rand_command(), rand_letter(), rand_letter());
      end
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      forever begin
         @(hold_trigger);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_results
      pair_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_pairs.size() == 0) begin
            if (failures < MAX_REPORTS) begin
               $display("ERROR: result with no item pending: first=%0d second=%0d flag=%0b",
                        rsp_ch.out_first, rsp_ch.out_second, rsp_ch.key_not_invertible);
            end
            failures++;
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_ch.out_first !== want.first || rsp_ch.out_second !== want.second ||
                rsp_ch.key_not_invertible !== want.bad_key) begin
               if (failures < MAX_REPORTS) begin
                  $display("ERROR: expected first=%0d second=%0d flag=%0b, got %0d %0d %0b",
                           want.first, want.second, want.bad_key, rsp_ch.out_first,
                           rsp_ch.out_second, rsp_ch.key_not_invertible);
               end
               failures++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_index            = hc26_pkg::REG_KEY_A;
      csr_write_data       = '0;
      req_ch.valid         = 1'b0;
      req_ch.command       = hc26_pkg::CMD_ENCRYPT;
      req_ch.letter_first  = '0;
      req_ch.letter_second = '0;
      foreach (key_reg[i]) begin
         key_reg[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_key();
      test_directed_keys();
      test_random_traffic();
      test_backpressure();
      wait_idle();
      repeat (PIPE_LATENCY * 4) @(posedge clock);
      if (expected_pairs.size() != 0) begin
         $display("ERROR: %0d results never arrived", expected_pairs.size());
         failures += expected_pairs.size();
      end

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/hc26_pkg.sv
hdl/hc26_if.sv
hdl/hc26_matrix.sv
hdl/hc26_lane.sv
hdl/hill_cipher_2x2_mod26.sv
tb/tb_hill_cipher_2x2_mod26.sv
